FILE: sv/eab_pkg.sv
// Shared types, codes and table lookup for the expansion board autoconfig block.
`default_nettype none

package eab_pkg;

    // Widths of the transfer fields.
    localparam int OP_W     = 2;
    localparam int OFF_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int NIB_W    = 4;
    localparam int STAT_W   = 2;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int TIDX_W   = 4;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_LOW   = 2'd2;
    localparam logic [STAT_W-1:0] ST_LOW_RPT  = 2'd3;

    // Board modes.
    localparam logic [MODE_W-1:0] MODE_CONFIG = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHUTUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ACTIVE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_FLAGS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_CODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRODUCT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MANUF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SERIAL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROM_VEC    = 3'd5;

    // Autoconfig space offsets.
    localparam logic [OFF_W-1:0] OFF_TABLE_END = 7'h30;
    localparam logic [OFF_W-1:0] OFF_ROM_END   = 7'h40;
    localparam logic [OFF_W-1:0] OFF_ZERO_A    = 7'h40;
    localparam logic [OFF_W-1:0] OFF_ZERO_B    = 7'h42;
    localparam logic [OFF_W-1:0] OFF_BASE_HI   = 7'h48;
    localparam logic [OFF_W-1:0] OFF_BASE_LO   = 7'h4A;
    localparam logic [OFF_W-1:0] OFF_SHUTUP    = 7'h4C;

    localparam logic [BYTE_W-1:0] ZORRO2_TYPE = 8'hC0;
    localparam logic [BYTE_W-1:0] BYTE_ONES   = 8'hFF;
    localparam logic [2:0]        SIZE_RESET  = 3'd1;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [OFF_W-1:0]  offset;
        logic [BYTE_W-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic [STAT_W-1:0] status;
        logic [MODE_W-1:0] board_state;
        logic [BYTE_W-1:0] base_address;
    } t_rsp;

    typedef struct packed {
        logic [2:0]  type_flags;
        logic [2:0]  size_code;
        logic [7:0]  product_id;
        logic [15:0] manufacturer_id;
        logic [31:0] serial_number;
        logic [15:0] rom_vector;
    } t_cfg;

    // One byte of the configuration table, selected by index.
    function automatic logic [BYTE_W-1:0] table_byte(input t_cfg cfg,
                                                     input logic [TIDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        b = '0;
        case (idx)
            4'd0:    b = ZORRO2_TYPE | {2'b00, cfg.type_flags, cfg.size_code};
            4'd1:    b = cfg.product_id;
            4'd4:    b = cfg.manufacturer_id[15:8];
            4'd5:    b = cfg.manufacturer_id[7:0];
            4'd6:    b = cfg.serial_number[31:24];
            4'd7:    b = cfg.serial_number[23:16];
            4'd8:    b = cfg.serial_number[15:8];
            4'd9:    b = cfg.serial_number[7:0];
            4'd10:   b = cfg.rom_vector[15:8];
            4'd11:   b = cfg.rom_vector[7:0];
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: sv/eab_cfg.sv
// Configuration register file of the autoconfig block.
`default_nettype none

module eab_cfg (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_wr_en,
    input  wire [eab_pkg::CFG_IDX_W-1:0]        i_index,
    input  wire [eab_pkg::CFG_DAT_W-1:0]        i_data,
    output eab_pkg::t_cfg                       o_cfg
);

    eab_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.type_flags      <= '0;
            r_cfg.size_code       <= eab_pkg::SIZE_RESET;
            r_cfg.product_id      <= '0;
            r_cfg.manufacturer_id <= '0;
            r_cfg.serial_number   <= '0;
            r_cfg.rom_vector      <= '0;
        end else if (i_wr_en) begin
            unique case (i_index)
                eab_pkg::REG_TYPE_FLAGS: r_cfg.type_flags      <= i_data[2:0];
                eab_pkg::REG_SIZE_CODE:  r_cfg.size_code       <= i_data[2:0];
                eab_pkg::REG_PRODUCT:    r_cfg.product_id      <= i_data[7:0];
                eab_pkg::REG_MANUF:      r_cfg.manufacturer_id <= i_data[15:0];
                eab_pkg::REG_SERIAL:     r_cfg.serial_number   <= i_data[31:0];
                eab_pkg::REG_ROM_VEC:    r_cfg.rom_vector      <= i_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: sv/eab_access.sv
// Access decoder and board state for the autoconfig block.
`default_nettype none

module eab_access (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_fire,
    input  wire eab_pkg::t_req     i_req,
    input  wire eab_pkg::t_cfg     i_cfg,
    output eab_pkg::t_rsp          o_rsp
);

    logic [eab_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [eab_pkg::BYTE_W-1:0] r_base, n_base;
    logic [eab_pkg::NIB_W-1:0]  r_hold, n_hold;
    logic                       r_low_seen, n_low_seen;

    logic [eab_pkg::BYTE_W-1:0] tbyte;
    logic [eab_pkg::NIB_W-1:0]  nib;
    logic [eab_pkg::BYTE_W-1:0] nib_byte;
    logic                       even;

    assign tbyte    = eab_pkg::table_byte(i_cfg, i_req.offset[5:2]);
    assign nib      = i_req.offset[1] ? tbyte[3:0] : tbyte[7:4];
    assign nib_byte = {nib, {eab_pkg::NIB_W{1'b0}}};
    assign even     = !i_req.offset[0];

    always_comb begin
        n_mode     = r_mode;
        n_base     = r_base;
        n_hold     = r_hold;
        n_low_seen = r_low_seen;
        o_rsp.read_data = eab_pkg::BYTE_ONES;
        o_rsp.status    = eab_pkg::ST_OK;
        unique case (i_req.operation)
            eab_pkg::OP_READ: begin
                if (even && i_req.offset < eab_pkg::OFF_TABLE_END) begin
                    if (r_mode == eab_pkg::MODE_CONFIG) begin
                        // The first nibble pair reads true, the rest inverted.
                        o_rsp.read_data = (i_req.offset[6:2] == '0) ? nib_byte : ~nib_byte;
                    end
                end else if (even && i_req.offset < eab_pkg::OFF_ROM_END) begin
                    o_rsp.read_data = eab_pkg::BYTE_ONES;
                end else if (i_req.offset == eab_pkg::OFF_ZERO_A ||
                             i_req.offset == eab_pkg::OFF_ZERO_B) begin
                    o_rsp.read_data = '0;
                end else begin
                    o_rsp.status = eab_pkg::ST_IGNORED;
                end
            end
            eab_pkg::OP_WRITE: begin
                if (r_mode != eab_pkg::MODE_CONFIG) begin
                    o_rsp.status = eab_pkg::ST_IGNORED;
                end else begin
                    unique case (i_req.offset)
                        eab_pkg::OFF_BASE_HI: begin
                            o_rsp.status = r_low_seen ? eab_pkg::ST_OK : eab_pkg::ST_NO_LOW;
                            n_base       = {i_req.write_data[7:4], r_hold};
                            n_mode       = eab_pkg::MODE_ACTIVE;
                            n_low_seen   = 1'b0;
                        end
                        eab_pkg::OFF_BASE_LO: begin
                            o_rsp.status = r_low_seen ? eab_pkg::ST_LOW_RPT : eab_pkg::ST_OK;
                            n_low_seen   = 1'b1;
                            n_hold       = i_req.write_data[7:4];
                        end
                        eab_pkg::OFF_SHUTUP: begin
                            n_mode     = eab_pkg::MODE_SHUTUP;
                            n_low_seen = 1'b0;
                        end
                        default: o_rsp.status = eab_pkg::ST_IGNORED;
                    endcase
                end
            end
            eab_pkg::OP_RESET: n_mode = eab_pkg::MODE_CONFIG;
            default:           o_rsp.status = eab_pkg::ST_IGNORED;
        endcase
        o_rsp.board_state  = n_mode;
        o_rsp.base_address = n_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= eab_pkg::MODE_CONFIG;
            r_base     <= '0;
            r_hold     <= '0;
            r_low_seen <= 1'b0;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_base     <= n_base;
            r_hold     <= n_hold;
            r_low_seen <= n_low_seen;
        end
    end

    // A pending low nibble only exists while the board is being configured.
    a_low_seen_config: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low_seen |-> r_mode == eab_pkg::MODE_CONFIG)
        else $error("low nibble pending outside config mode");

    // A base write in config mode activates the board.
    a_base_activates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.operation == eab_pkg::OP_WRITE &&
         i_req.offset == eab_pkg::OFF_BASE_HI && r_mode == eab_pkg::MODE_CONFIG)
        |=> r_mode == eab_pkg::MODE_ACTIVE && !r_low_seen)
        else $error("base write did not activate board");

    // Without an accepted transfer the board state holds.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_mode) && $stable(r_base) && $stable(r_low_seen))
        else $error("board state changed without a transfer");

endmodule

`default_nettype wire

FILE: sv/expansion_autoconfig_board.sv
// Top level of the expansion board autoconfig register space.
//
//  channel   direction   handshake                       payload
//  -------   ---------   -----------------------------   ----------------------------
//  request   in          i_in_valid / o_in_ready         i_in_data   (eab_pkg::t_req)
//  result    out         o_out_valid / i_out_ready       o_out_data  (eab_pkg::t_rsp)
//  config    in          i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// Each request transfer produces exactly one result in the next cycle, from a
// single decode step between the request port and the result register.
// A new request is taken every cycle while the result register is empty or
// its content is being taken in the same cycle, so the rate is one per cycle.
// A stall on the result side holds the result register and blocks requests.
// Reset (synchronous, active low) empties the result register, returns the
// board to config mode and loads the configuration register defaults.
`default_nettype none

module expansion_autoconfig_board (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire eab_pkg::t_req               i_in_data,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output eab_pkg::t_rsp                    o_out_data,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [eab_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [eab_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    eab_pkg::t_cfg cfg;
    eab_pkg::t_rsp n_out;
    eab_pkg::t_rsp r_out;
    logic          r_out_valid;
    logic          in_fire;

    // Configuration writes are always accepted.
    assign o_cfg_ready = 1'b1;

    // The result register frees up in the same cycle its content is taken.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    eab_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    eab_access u_access (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_req   (i_in_data),
        .i_cfg   (cfg),
        .o_rsp   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload needs no reset; it is loaded with every request transfer.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A request is never taken while an untaken result sits in the register.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("request accepted over a stalled result");

    // A base write without a held low nibble always leaves the board active.
    a_nolow_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == eab_pkg::ST_NO_LOW)
        |-> r_out.board_state == eab_pkg::MODE_ACTIVE)
        else $error("base status without active board");

    // Every request transfer yields a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("request transfer produced no result");

endmodule

`default_nettype wire
